// ===== rtl/core/booth_r4_pkg.sv =====
`default_nettype none
package booth_r4_pkg;

  localparam int IN_W   = 16;
  localparam int PROD_W = 32;
  localparam int CNT_W  = 4;

  typedef struct packed {
    logic signed [IN_W-1:0] multiplicand;
    logic signed [IN_W-1:0] multiplier;
  } operand_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [CNT_W-1:0]         add_sub_count;
  } result_t;

  // Partial sums are kept modulo 2**PROD_W: only the low product bits leave the block.
  typedef struct packed {
    logic [PROD_W-1:0] acc;
    logic [PROD_W-1:0] mcand;
    logic [PROD_W-1:0] mplier;
    logic [CNT_W-1:0]  cnt;
  } stage_t;

  typedef struct packed {
    logic nonzero;
    logic negate;
    logic twice;
  } digit_t;

  // Recode one bit triple {q[2i+1], q[2i], q[2i-1]} into a Booth digit.
  function automatic digit_t booth_decode(input logic [2:0] trip);
    digit_t d;
    d.nonzero = (trip[2] ^ trip[1]) | (trip[1] ^ trip[0]);
    d.negate  = trip[2];
    d.twice   = (trip[2] ^ trip[1]) & ~(trip[1] ^ trip[0]);
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/booth_r4_cell.sv =====
`default_nettype none
module booth_r4_cell import booth_r4_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   valid_in,
  input  wire stage_t stage_in,
  output logic        valid_out,
  output stage_t      stage_out
);

  logic [PROD_W:0]   qz;
  logic [2:0]        trip;
  digit_t            dig;
  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] term;
  stage_t            stage_next;

  // Append the implicit zero below bit 0 so every cell reads a full triple.
  assign qz   = {stage_in.mplier, 1'b0};
  assign trip = qz[2*IDX+2 -: 3];
  assign dig  = booth_decode(trip);

  always_comb begin
    mag = dig.twice ? {stage_in.mcand[PROD_W-2:0], 1'b0} : stage_in.mcand;
    if (!dig.nonzero) begin
      term = '0;
    end else if (dig.negate) begin
      term = (~mag) + PROD_W'(1);
    end else begin
      term = mag;
    end
    stage_next        = stage_in;
    stage_next.acc    = stage_in.acc + (term << (2 * IDX));
    stage_next.cnt    = stage_in.cnt + CNT_W'(dig.nonzero);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage_out <= stage_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/booth_radix4_multiplier_unit.sv =====
`default_nettype none
// Radix-4 Booth multiplier, signed WIDTH x WIDTH, pipelined one digit per cell.
//
// Input: raise start with operand (multiplicand, multiplier) for one beat.
// busy is always low, so a new beat is taken on every cycle that start is high.
// Only the low WIDTH bits of each operand are used; bit WIDTH-1 is the sign.
//
// Output: done pulses for one cycle with result (product, add_sub_count).
// product is the low 32 bits of the signed product; add_sub_count is the
// number of nonzero Booth digits, modulo 16.
//
// The chain has one cell per Booth digit, each cell one register stage.
// Throughput is one beat per cycle. Results come out in order.
// The receiver cannot stall; it must take result in the cycle done is high.
// Reset clears all in-flight beats; no result appears for them.
module booth_radix4_multiplier_unit import booth_r4_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire operand_t operand,
  output logic          done,
  output result_t       result
);

  localparam int DIGITS = (WIDTH + 1) / 2;

  logic [PROD_W-1:0] mc_raw;
  logic [PROD_W-1:0] mq_raw;
  stage_t            head;
  logic              valid_chain [DIGITS+1];
  stage_t            stage_chain [DIGITS+1];

  assign busy = 1'b0;

  // Sign-extend from bit WIDTH-1; bits above the 16-bit field read as zero.
  assign mc_raw = PROD_W'(unsigned'(operand.multiplicand));
  assign mq_raw = PROD_W'(unsigned'(operand.multiplier));

  always_comb begin
    head.acc = '0;
    head.cnt = '0;
    for (int k = 0; k < PROD_W; k++) begin
      head.mcand[k] = (k < WIDTH) ? mc_raw[k] : mc_raw[WIDTH-1];
      head.mplier[k] = (k < WIDTH) ? mq_raw[k] : mq_raw[WIDTH-1];
    end
  end

  assign valid_chain[0] = start & ~busy;
  assign stage_chain[0] = head;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    booth_r4_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_chain[i]),
      .stage_in  (stage_chain[i]),
      .valid_out (valid_chain[i+1]),
      .stage_out (stage_chain[i+1])
    );
  end

  assign done                 = valid_chain[DIGITS];
  assign result.product       = signed'(stage_chain[DIGITS].acc);
  assign result.add_sub_count = stage_chain[DIGITS].cnt;

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    done |-> ((DIGITS >= 16) || (32'(result.add_sub_count) <= DIGITS)))
    else $error("add_sub_count exceeds digit count");

  a_zero_mcand : assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (operand.multiplicand == '0), DIGITS))
      |-> (result.product == '0))
    else $error("zero multiplicand gave nonzero product");

  a_zero_mplier : assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && (operand.multiplier == '0), DIGITS))
      |-> ((result.product == '0) && (result.add_sub_count == '0)))
    else $error("zero multiplier gave nonzero product or count");

endmodule
`default_nettype wire
